// ----- design/dmn_pkg.sv -----
package dmn_pkg;

	// Default sizing of the node
	localparam int NODES_DEF      = 16;
	localparam int STAMP_BITS_DEF = 48;

	// Fixed field widths
	localparam int STAMP_W    = 48;
	localparam int NODE_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Queue depths between the parts
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	// Input actions
	localparam logic [1:0] ACT_ACQUIRE = 2'd0;
	localparam logic [1:0] ACT_REQUEST = 2'd1;
	localparam logic [1:0] ACT_REPLY   = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	// Outgoing message kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_REQ     = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;
	localparam logic [1:0] KIND_RELEASE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

	typedef struct packed {
		logic [1:0]         action;
		logic [STAMP_W-1:0] stamp;
		logic [NODE_W-1:0]  source;
	} item_t;

	typedef struct packed {
		logic [1:0]         send_kind;
		logic [NODE_W-1:0]  dest;
		logic [STAMP_W-1:0] out_stamp;
		logic               granted;
		logic               last;
	} result_t;

	// Decoded request handed from front to back
	typedef struct packed {
		logic [1:0]         action;
		logic [STAMP_W-1:0] stamp;
		logic [NODE_W-1:0]  source;
		logic               src_out;
		logic               src_self;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0]  rank;
		logic [COUNT_W-1:0] count;
	} cfg_t;

endpackage

// ----- design/dmn_fifo.sv -----
module dmn_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     wdata,
	input  logic pop,
	output logic empty,
	output T     rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (do_pop) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- design/dmn_front.sv -----
module dmn_front #(
	parameter int NODES      = dmn_pkg::NODES_DEF,
	parameter int STAMP_BITS = dmn_pkg::STAMP_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  dmn_pkg::item_t item,
	input  dmn_pkg::cfg_t  cfg,
	output logic           cmd_valid,
	input  logic           cmd_pop,
	output dmn_pkg::cmd_t  cmd
);
	import dmn_pkg::*;

	localparam int SW       = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;
	localparam int SRC_SPAN = 1 << NODE_W;
	localparam logic [STAMP_W-1:0] SMASK =
		(SW >= STAMP_W) ? '1 : ((STAMP_W'(1) << SW) - STAMP_W'(1));

	cmd_t dec;
	logic cmd_empty;

	// classify: mask the stamp, flag sources that must be ignored
	always_comb begin
		dec.action   = item.action;
		dec.stamp    = item.stamp & SMASK;
		dec.source   = item.source;
		dec.src_out  = (NODES < SRC_SPAN) ? (item.source >= NODE_W'(NODES)) : 1'b0;
		dec.src_self = item.source == cfg.rank;
	end

	dmn_fifo #(
		.T     (cmd_t),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (dec),
		.pop   (cmd_pop),
		.empty (cmd_empty),
		.rdata (cmd)
	);

	assign cmd_valid = !cmd_empty;

endmodule

// ----- design/dmn_back.sv -----
module dmn_back #(
	parameter int NODES      = dmn_pkg::NODES_DEF,
	parameter int STAMP_BITS = dmn_pkg::STAMP_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dmn_pkg::cfg_t    cfg,
	input  logic             cmd_valid,
	input  dmn_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output dmn_pkg::result_t res
);
	import dmn_pkg::*;

	localparam int SW = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;
	localparam int IW = $clog2(NODES);
	// collected count may reach NODES + 1 when the rank lies outside the set
	localparam int CW = $clog2(NODES + 2);
	localparam int EW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic            req_q;
	logic [SW-1:0]   own_q;
	logic [NODES-1:0] set_q;
	logic [CW-1:0]   got_q;
	logic [NODES-1:0] dv_q;
	logic            held_q;
	logic [IW-1:0]   ptr_q;
	logic [IW-1:0]   dest_q;
	logic            last_q;
	logic [SW-1:0]   rd_q;
	logic [SW-1:0]   stamp_mem [NODES];

	logic [SW-1:0]    st;
	logic [IW-1:0]    src_i;
	logic [EW-1:0]    ncnt;
	logic [EW-1:0]    eff;
	logic             rank_in;
	logic             single;
	logic             ignore;
	logic             answer;
	logic             match;
	logic [CW-1:0]    got_next;
	logic             full_next;
	logic             scan_bit;
	logic [NODES-1:0] rest;
	logic             mem_we;
	logic             mem_re;

	// decision terms
	always_comb begin
		st        = cmd.stamp[SW-1:0];
		src_i     = IW'(cmd.source);
		ncnt      = EW'(cfg.count);
		if (ncnt == '0) eff = EW'(1);
		else if (ncnt > EW'(NODES)) eff = EW'(NODES);
		else eff = ncnt;
		rank_in   = EW'(cfg.rank) < EW'(NODES);
		single    = eff == EW'(1);
		ignore    = cmd.src_out || cmd.src_self;
		answer    = !req_q || (st < own_q) || ((st == own_q) && (cmd.source < cfg.rank));
		match     = !cmd.src_out && req_q && (st == own_q);
		got_next  = got_q + CW'(!set_q[src_i]);
		full_next = EW'(got_next) >= eff;
		scan_bit  = dv_q[ptr_q];
		rest      = dv_q & ~(NODES'(1) << ptr_q);
	end

	// result formation and queue handshakes
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop     = 1'b1;
					res_push    = 1'b1;
					res.last    = 1'b1;
					res.granted = held_q;
					case (cmd.action)
						ACT_ACQUIRE: begin
							res.send_kind = KIND_REQ;
							res.out_stamp = STAMP_W'(st);
							res.granted   = single;
						end
						ACT_REQUEST: begin
							if (!ignore && answer) begin
								res.send_kind = KIND_REPLY;
								res.dest      = cmd.source;
								res.out_stamp = STAMP_W'(st);
							end else if (!ignore) begin
								mem_we = 1'b1;
							end
						end
						ACT_REPLY: begin
							res.granted = held_q || (match && full_next);
						end
						default: begin
							res.send_kind = KIND_RELEASE;
							res.granted   = 1'b0;
							res.last      = dv_q == '0;
						end
					endcase
				end
			end
			ST_SCAN: begin
				mem_re = scan_bit;
			end
			ST_EMIT: begin
				res_push      = !res_full;
				res.send_kind = KIND_REPLY;
				res.dest      = NODE_W'(dest_q);
				res.out_stamp = STAMP_W'(rd_q);
				res.granted   = held_q;
				res.last      = last_q;
			end
			default: ;
		endcase
	end

	// deferred stamps, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) stamp_mem[src_i] <= st;
		if (mem_re) rd_q <= stamp_mem[ptr_q];
	end

	// lock state and release walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= 1'b0;
			own_q   <= '0;
			set_q   <= '0;
			got_q   <= '0;
			dv_q    <= '0;
			held_q  <= 1'b0;
			ptr_q   <= '0;
			dest_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.action)
							ACT_ACQUIRE: begin
								set_q  <= rank_in ? (NODES'(1) << cfg.rank) : '0;
								got_q  <= CW'(1);
								own_q  <= st;
								req_q  <= 1'b1;
								held_q <= single;
							end
							ACT_REQUEST: begin
								if (!ignore && !answer) dv_q[src_i] <= 1'b1;
							end
							ACT_REPLY: begin
								if (match) begin
									set_q[src_i] <= 1'b1;
									got_q        <= got_next;
									if (full_next) held_q <= 1'b1;
								end
							end
							default: begin
								req_q  <= 1'b0;
								held_q <= 1'b0;
								ptr_q  <= '0;
								if (dv_q != '0) state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_bit) begin
						dv_q    <= rest;
						dest_q  <= ptr_q;
						last_q  <= rest == '0;
						state_q <= ST_EMIT;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q + IW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/distributed_mutex_node_core.sv -----
// One node of a Ricart-Agrawala timestamp lock. Items (acquire, request
// received, reply received, release) go in through a queue-style push/full
// port and outgoing messages come out through empty/pop, oldest first; the
// last flag marks the final message caused by one item. A two-entry command
// queue parts the decoder from the lock sequencer, and a two-entry result
// queue parts the sequencer from the consumer, so either side may stall.
// Acquire, request and reply items pass through the command queue and the
// result queue, and the sequencer retires one of them per cycle while it is
// idle and the result queue has room. A release emits the release message,
// then walks the deferred slots one index per cycle, and each deferred reply
// waits for the single registered read port of the stamp memory before it
// is emitted. Write node_rank and node_count through the cfg port only while
// the node is idle.
module distributed_mutex_node_core #(
	parameter int NODES      = dmn_pkg::NODES_DEF,
	parameter int STAMP_BITS = dmn_pkg::STAMP_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  dmn_pkg::item_t                      item,
	output logic                                empty,
	input  logic                                pop,
	output dmn_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dmn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmn_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dmn_pkg::*;

	cfg_t    cfg_q;
	logic    cmd_valid;
	logic    cmd_pop;
	cmd_t    cmd;
	logic    res_full;
	logic    res_push;
	result_t res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank  <= '0;
			cfg_q.count <= COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NODE_RANK:  cfg_q.rank  <= cfg_data[NODE_W-1:0];
				CFG_NODE_COUNT: cfg_q.count <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	dmn_front #(
		.NODES     (NODES),
		.STAMP_BITS(STAMP_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	dmn_back #(
		.NODES     (NODES),
		.STAMP_BITS(STAMP_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	dmn_fifo #(
		.T     (result_t),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (res),
		.pop   (pop),
		.empty (empty),
		.rdata (result)
	);

endmodule

// ----- design/dmn_checker.sv -----
module dmn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pop,
	input logic             empty,
	input dmn_pkg::result_t result
);
	import dmn_pkg::*;

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	// release and its deferred replies never show the lock held
	a_rel_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last) |-> !result.granted)
		else $error("granted set inside a release sequence");

	// only a release or a deferred reply may leave more results to follow
	a_nonlast_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last) |->
		(result.send_kind == KIND_RELEASE || result.send_kind == KIND_REPLY))
		else $error("non-final result of unexpected kind");

	// what follows a non-final result is a deferred reply
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last) |=>
		(empty || result.send_kind == KIND_REPLY))
		else $error("release sequence broken");

endmodule

bind distributed_mutex_node_core dmn_checker u_dmn_checker (.*);

// ----- tb/sv/distributed_mutex_node_core_test.sv -----
`timescale 1ns / 100ps

module distributed_mutex_node_core_test;
	import dmn_pkg::*;

	localparam int NODES       = NODES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 22;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 40;

	// Index codes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// Idling modes
	localparam int MODE_STEADY  = 0;
	localparam int MODE_TX_IDLE = 1;
	localparam int MODE_RX_IDLE = 2;
	localparam int MODE_BOTH    = 3;

	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		item_t                 it;
		bit                    typed;
		result_t               want;
	} step_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	item_t                 item_in   = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               msg_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Lock state as the node should hold it
	logic [NODE_W-1:0]  m_rank     = '0;
	logic [COUNT_W-1:0] m_count    = 5'd1;
	bit                 m_req      = 1'b0;
	logic [STAMP_W-1:0] m_own      = '0;
	logic [NODES-1:0]   m_replies  = '0;
	logic [NODES-1:0]   m_defer_v  = '0;
	logic [STAMP_W-1:0] m_defer_st [NODES];
	bit                 m_held     = 1'b0;

	result_t msg_q [$];
	step_row_t dir_tab [$];

	int fails        = 0;
	int items_sent   = 0;
	int msgs_checked = 0;
	int cfg_writes   = 0;
	int cycles       = 0;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit hold_rx      = 1'b0;
	bit hold_used    = 1'b0;
	int hold_left    = 0;

	distributed_mutex_node_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item_in),
		.empty     (empty),
		.pop       (pop),
		.result    (msg_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d messages outstanding", cycles, msg_q.size());
			$display("FAIL distributed_mutex_node_core");
			$finish;
		end
	end

	// Append one expected message at the tail
	task automatic queue_msg(input result_t r);
		msg_q.insert(msg_q.size(), r);
	endtask

	// Append one row to the directed table
	task automatic add_row(input step_row_t row);
		dir_tab.insert(dir_tab.size(), row);
	endtask

	// Collected set reaches the effective node count
	function automatic bit lock_complete();
		int got;
		int need;
		got = 0;
		for (int i = 0; i < NODES; i++)
			got += m_replies[i];
		if (m_count == 0)
			need = 1;
		else if (m_count > NODES)
			need = NODES;
		else
			need = m_count;
		return got >= need;
	endfunction

	// Messages one request causes, in emission order
	task automatic predict_messages(input item_t it, input bit record);
		result_t r;
		result_t outs [$];
		logic [NODES-1:0] left;
		r = '0;
		r.last = 1'b1;
		case (it.action)
			ACT_ACQUIRE: begin
				m_replies = '0;
				m_replies[m_rank] = 1'b1;
				m_own = it.stamp;
				m_req = 1'b1;
				m_held = lock_complete();
				r.send_kind = KIND_REQ;
				r.out_stamp = it.stamp;
			end
			ACT_REQUEST: begin
				if (it.source == m_rank) begin
					r.send_kind = KIND_NONE;
				end else if (!m_req || it.stamp < m_own ||
						(it.stamp == m_own && it.source < m_rank)) begin
					r.send_kind = KIND_REPLY;
					r.dest = it.source;
					r.out_stamp = it.stamp;
				end else begin
					// later stamp from the same source overwrites
					m_defer_v[it.source] = 1'b1;
					m_defer_st[it.source] = it.stamp;
				end
			end
			ACT_REPLY: begin
				if (m_req && it.stamp == m_own) begin
					m_replies[it.source] = 1'b1;
					if (lock_complete())
						m_held = 1'b1;
				end
			end
			default: begin
				// release, then deferred replies in node order
				m_req = 1'b0;
				m_held = 1'b0;
				left = m_defer_v;
				r.send_kind = KIND_RELEASE;
				r.last = (left == '0);
				outs.insert(outs.size(), r);
				for (int i = 0; i < NODES; i++) begin
					if (left[i]) begin
						left[i] = 1'b0;
						r.send_kind = KIND_REPLY;
						r.dest = NODE_W'(i);
						r.out_stamp = m_defer_st[i];
						r.last = (left == '0);
						outs.insert(outs.size(), r);
					end
				end
				m_defer_v = '0;
			end
		endcase
		if (it.action != ACT_RELEASE) begin
			r.granted = m_held;
			outs.insert(outs.size(), r);
		end
		if (record)
			foreach (outs[k])
				queue_msg(outs[k]);
	endtask

	// Compare one popped message with the oldest one waiting
	task automatic check_message(input result_t got);
		result_t want;
		msgs_checked++;
		if (msg_q.size() == 0) begin
			$error("unexpected message: send_kind %0d dest %0d out_stamp %0h",
				got.send_kind, got.dest, got.out_stamp);
			fails++;
		end else begin
			want = msg_q.pop_front();
			if (got.send_kind !== want.send_kind) begin
				$error("send_kind: expected %0d, got %0d", want.send_kind, got.send_kind);
				fails++;
			end
			if (got.dest !== want.dest) begin
				$error("dest: expected %0d, got %0d", want.dest, got.dest);
				fails++;
			end
			if (got.out_stamp !== want.out_stamp) begin
				$error("out_stamp: expected %0h, got %0h", want.out_stamp, got.out_stamp);
				fails++;
			end
			if (got.granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, got.granted);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				fails++;
			end
		end
	endtask

	// Consumer side: check, then decide pop for the next cycle
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_message(msg_out);
			if (hold_rx && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_item(input item_t it, input bit record);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			if ($urandom_range(99) < tx_idle_pct) begin
				push <= 1'b0;
				@(posedge clk);
			end else begin
				push <= 1'b1;
				item_in <= it;
				@(posedge clk);
				if (!full)
					taken = 1'b1;
			end
		end
		items_sent++;
		predict_messages(it, record);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_NODE_RANK:  m_rank = data[NODE_W-1:0];
			CFG_NODE_COUNT: m_count = data[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Stop offering and let every expected message drain
	task automatic wait_idle();
		push <= 1'b0;
		while (msg_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [STAMP_W-1:0] pick_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(3))
			0, 1: return w[STAMP_W-1:0];
			2: return STAMP_W'(w[3:0]);
			default: return STAMP_MAX - STAMP_W'(w[3:0]);
		endcase
	endfunction

	function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		step_row_t row;
		row = '{1'b1, idx, data, '0, 1'b0, '0};
		return row;
	endfunction

	function automatic step_row_t item_row(input logic [1:0] act,
			input logic [STAMP_W-1:0] st, input logic [NODE_W-1:0] src);
		step_row_t row;
		row = '{1'b0, '0, '0, '{act, st, src}, 1'b0, '0};
		return row;
	endfunction

	function automatic step_row_t typed_row(input logic [1:0] act,
			input logic [STAMP_W-1:0] st, input logic [NODE_W-1:0] src,
			input logic [1:0] kind, input logic [NODE_W-1:0] dst,
			input logic [STAMP_W-1:0] ost, input logic gr);
		step_row_t row;
		row = '{1'b0, '0, '0, '{act, st, src}, 1'b1, '{kind, dst, ost, gr, 1'b1}};
		return row;
	endfunction

	// One lock round: acquire, replies and foreign requests mixed, usually a release
	task automatic run_session();
		item_t it;
		logic [STAMP_W-1:0] s;
		int order [NODES];
		int n;
		int k;
		int j;
		int t;
		s = pick_stamp();
		it.action = ACT_ACQUIRE;
		it.stamp = s;
		it.source = NODE_W'($urandom);
		send_item(it, 1'b1);
		for (int i = 0; i < NODES; i++)
			order[i] = i;
		for (int i = NODES - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		n = $urandom_range(1) ? NODES : $urandom_range(NODES, 0);
		k = 0;
		while (k < n) begin
			if ($urandom_range(3) == 0) begin
				it.action = ACT_REQUEST;
				it.source = NODE_W'($urandom);
				case ($urandom_range(4))
					0: it.stamp = s - 1'b1;
					1: it.stamp = s;
					2: it.stamp = s + 1'b1;
					3: it.stamp = s + 2'd2;
					default: it.stamp = pick_stamp();
				endcase
			end else begin
				// mostly matching replies, now and then a stale one
				it.action = ACT_REPLY;
				it.source = NODE_W'(order[k]);
				it.stamp = ($urandom_range(9) == 0) ?
					s ^ (48'd1 << $urandom_range(STAMP_W - 1)) : s;
				k++;
			end
			send_item(it, 1'b1);
		end
		if ($urandom_range(9) != 0) begin
			it.action = ACT_RELEASE;
			it.stamp = pick_stamp();
			it.source = NODE_W'($urandom);
			send_item(it, 1'b1);
		end
	endtask

	// Stimulus
	initial begin
		item_t it;
		step_row_t row;
		logic [CFG_DATA_W-1:0] pr;
		logic [CFG_DATA_W-1:0] pc;
		int mode;
		int start;
		foreach (m_defer_st[i])
			m_defer_st[i] = '0;

		// directed: reset settings (rank 0, one node)
		add_row(typed_row(ACT_RELEASE, '0, 4'd0, KIND_RELEASE, 4'd0, '0, 1'b0));
		add_row(typed_row(ACT_REQUEST, STAMP_MAX, 4'd5, KIND_REPLY, 4'd5,
			STAMP_MAX, 1'b0));
		add_row(typed_row(ACT_REQUEST, 48'd123, 4'd0, KIND_NONE, 4'd0, '0, 1'b0));
		add_row(typed_row(ACT_ACQUIRE, '0, 4'd0, KIND_REQ, 4'd0, '0, 1'b1));
		add_row(item_row(ACT_REQUEST, '0, 4'd15));
		add_row(item_row(ACT_REQUEST, STAMP_MAX, 4'd3));
		add_row(item_row(ACT_REQUEST, 48'd5, 4'd3));
		add_row(item_row(ACT_REPLY, 48'd7, 4'd2));
		add_row(item_row(ACT_RELEASE, '0, 4'd0));
		// rank 15 of two; unused indexes must not disturb anything
		add_row(cfg_row(CFG_NODE_RANK, 8'hFF));
		add_row(cfg_row(CFG_NODE_COUNT, 8'h02));
		add_row(cfg_row(CFG_SPARE_A, 8'hAA));
		add_row(cfg_row(CFG_SPARE_B, 8'h55));
		add_row(item_row(ACT_ACQUIRE, 48'd100, 4'd0));
		add_row(item_row(ACT_REQUEST, 48'd100, 4'd0));
		add_row(item_row(ACT_REQUEST, 48'd101, 4'd14));
		add_row(item_row(ACT_REPLY, 48'd99, 4'd4));
		add_row(item_row(ACT_REPLY, 48'd100, 4'd4));
		add_row(item_row(ACT_REQUEST, 48'd50, 4'd9));
		add_row(item_row(ACT_RELEASE, STAMP_MAX, 4'd15));
		// zero count acts as one node
		add_row(cfg_row(CFG_NODE_COUNT, 8'h00));
		add_row(typed_row(ACT_ACQUIRE, STAMP_MAX, 4'd0, KIND_REQ, 4'd0,
			STAMP_MAX, 1'b1));
		add_row(typed_row(ACT_RELEASE, '0, 4'd0, KIND_RELEASE, 4'd0, '0, 1'b0));
		// count above the node limit is clipped
		add_row(cfg_row(CFG_NODE_RANK, 8'h00));
		add_row(cfg_row(CFG_NODE_COUNT, 8'hF4));
		add_row(item_row(ACT_ACQUIRE, 48'h8000_0000_0001, 4'd0));
		add_row(item_row(ACT_REPLY, 48'h8000_0000_0001, 4'd15));
		add_row(item_row(ACT_RELEASE, '0, 4'd0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.is_cfg) begin
				wait_idle();
				cfg_write(row.idx, row.data);
			end else begin
				send_item(row.it, !row.typed);
				if (row.typed)
					queue_msg(row.want);
			end
		end

		// random phases, each with its own settings and idling
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: begin pr = 8'h00; pc = 8'h10; mode = MODE_STEADY;  end
				1: begin pr = 8'h0F; pc = 8'h04; mode = MODE_TX_IDLE; end
				2: begin pr = 8'hF7; pc = 8'h1F; mode = MODE_RX_IDLE; end
				3: begin pr = 8'h03; pc = 8'h00; mode = MODE_BOTH;    end
				4: begin pr = 8'h0A; pc = 8'h03; mode = MODE_STEADY;  end
				5: begin pr = 8'h05; pc = 8'hE2; mode = MODE_TX_IDLE; end
				6: begin
					pr = CFG_DATA_W'($urandom);
					pc = CFG_DATA_W'($urandom);
					mode = MODE_RX_IDLE;
				end
				default: begin pr = 8'h0F; pc = 8'h10; mode = MODE_BOTH; end
			endcase
			@(negedge clk);
			tx_idle_pct = (mode == MODE_TX_IDLE) ? 62 : (mode == MODE_BOTH) ? 20 : 0;
			rx_stall_pct = (mode == MODE_RX_IDLE) ? 62 : (mode == MODE_BOTH) ? 20 : 0;
			// long consumer hold in one steady phase fills the node
			hold_rx = (p == 4);
			cfg_write(CFG_NODE_RANK, pr);
			cfg_write(CFG_NODE_COUNT, pc);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(4) == 0) begin
					it.action = 2'($urandom);
					it.stamp = pick_stamp();
					it.source = NODE_W'($urandom);
					send_item(it, 1'b1);
				end else begin
					run_session();
				end
			end
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d lock requests and %0d outgoing messages over %0d register writes,",
			items_sent, msgs_checked, cfg_writes);
		$display("with gaps on both sides and one long consumer hold that backed up the input.");
		if (fails == 0)
			$display("PASS distributed_mutex_node_core");
		else
			$display("FAIL distributed_mutex_node_core");
		$finish;
	end

endmodule
